[rtl/bcd_hour_clock_with_prescaler_assert.svh]
// assertion macros for the hour clock
`ifndef BCD_HOUR_CLOCK_WITH_PRESCALER_ASSERT_SVH
`define BCD_HOUR_CLOCK_WITH_PRESCALER_ASSERT_SVH

// same-cycle implication
`define BHC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hour clock check failed");

// next-cycle implication
`define BHC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hour clock check failed");

`endif

[rtl/bhc_pkg.sv]
`timescale 1ns / 1ps

package bhc_pkg;

    localparam int PHASE_BITS = 3;

    localparam logic [5:0]  TILE_BASE        = 6'h30;
    localparam logic [4:0]  MAX_HOUR         = 5'd23;
    localparam logic [15:0] HOUR_LENGTH_RST  = 16'd300;
    localparam logic [4:0]  START_HOUR_RST   = 5'd12;
    localparam logic [13:0] CELL_ADDRESS_RST = 14'h2038;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_DRAW  = 2'd1;
    localparam logic [1:0] ACT_BLANK = 2'd2;

    localparam int ADDR_BITS = 4;
    localparam logic [1:0] REG_HOUR_LENGTH  = 2'd0;
    localparam logic [1:0] REG_START_HOUR   = 2'd1;
    localparam logic [1:0] REG_CELL_ADDRESS = 2'd2;

    typedef struct packed {
        logic       enabled;
        logic [2:0] frame_phase;
    } in_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [13:0] write_address;
        logic [5:0]  tile_tens;
        logic [5:0]  tile_ones;
        logic [1:0]  hour_tens;
        logic [3:0]  hour_ones;
    } out_t;

    typedef struct packed {
        logic [15:0] hour_length;
        logic [4:0]  start_hour;
        logic [13:0] cell_address;
    } cfg_t;

    typedef struct packed {
        logic [15:0] frames_left;
        logic [1:0]  tens_digit;
        logic [3:0]  ones_digit;
        logic        seeded;
    } clk_state_t;

    // split a saturated hour into bcd digits
    function automatic logic [5:0] hour_to_bcd(input logic [4:0] hour);
        logic [4:0] h;
        logic [1:0] tens;
        logic [4:0] ones;
        begin
            h = (hour > MAX_HOUR) ? MAX_HOUR : hour;
            if (h >= 5'd20) begin
                tens = 2'd2;
                ones = h - 5'd20;
            end else if (h >= 5'd10) begin
                tens = 2'd1;
                ones = h - 5'd10;
            end else begin
                tens = 2'd0;
                ones = h;
            end
            hour_to_bcd = {tens, ones[3:0]};
        end
    endfunction

endpackage

[rtl/bhc_cfg.sv]
`timescale 1ns / 1ps

module bhc_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bhc_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output bhc_pkg::cfg_t               cfg
);

    bhc_pkg::cfg_t cfg_reg;
    bhc_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[3:2])
                bhc_pkg::REG_HOUR_LENGTH:  cfg_next.hour_length  = pwdata[15:0];
                bhc_pkg::REG_START_HOUR:   cfg_next.start_hour   = pwdata[4:0];
                bhc_pkg::REG_CELL_ADDRESS: cfg_next.cell_address = pwdata[13:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            bhc_pkg::REG_HOUR_LENGTH:  prdata = {16'd0, cfg_reg.hour_length};
            bhc_pkg::REG_START_HOUR:   prdata = {27'd0, cfg_reg.start_hour};
            bhc_pkg::REG_CELL_ADDRESS: prdata = {18'd0, cfg_reg.cell_address};
            default: prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hour_length  <= bhc_pkg::HOUR_LENGTH_RST;
            cfg_reg.start_hour   <= bhc_pkg::START_HOUR_RST;
            cfg_reg.cell_address <= bhc_pkg::CELL_ADDRESS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/bhc_step.sv]
`timescale 1ns / 1ps

module bhc_step (
    input  bhc_pkg::in_t       req,
    input  bhc_pkg::cfg_t      cfg,
    input  bhc_pkg::clk_state_t cur,
    output bhc_pkg::clk_state_t nxt,
    output bhc_pkg::out_t      res
);

    logic [5:0] seed_bcd;
    logic [3:0] ones_inc;
    logic [1:0] tens_inc;
    logic [3:0] ones_adv;
    logic [1:0] tens_adv;
    logic       any_state;

    assign seed_bcd  = bhc_pkg::hour_to_bcd(cfg.start_hour);
    assign any_state = (cur.frames_left != 16'd0) || (cur.tens_digit != 2'd0)
                    || (cur.ones_digit != 4'd0) || cur.seeded;

    // bcd increment with 23 to 00 wrap
    always_comb begin
        ones_inc = cur.ones_digit + 4'd1;
        tens_inc = cur.tens_digit;
        if (ones_inc >= 4'd10) begin
            ones_inc = 4'd0;
            tens_inc = cur.tens_digit + 2'd1;
        end
        if (tens_inc == 2'd2 && ones_inc == 4'd4) begin
            tens_adv = 2'd0;
            ones_adv = 4'd0;
        end else begin
            tens_adv = tens_inc;
            ones_adv = ones_inc;
        end
    end

    always_comb begin
        nxt = cur;
        res = '0;
        if (!req.enabled) begin
            if (any_state) begin
                nxt               = '0;
                res.action        = bhc_pkg::ACT_BLANK;
                res.write_address = cfg.cell_address;
            end
        end else begin
            if (!cur.seeded) begin
                nxt.tens_digit  = seed_bcd[5:4];
                nxt.ones_digit  = seed_bcd[3:0];
                nxt.seeded      = 1'b1;
                nxt.frames_left = cfg.hour_length;
            end else if (cur.frames_left == 16'd0) begin
                nxt.tens_digit  = tens_adv;
                nxt.ones_digit  = ones_adv;
                nxt.frames_left = cfg.hour_length;
            end else begin
                nxt.frames_left = cur.frames_left - 16'd1;
            end
            if (req.frame_phase[bhc_pkg::PHASE_BITS-1:0] == '0) begin
                res.action        = bhc_pkg::ACT_DRAW;
                res.write_address = cfg.cell_address;
                res.tile_tens     = {4'd0, nxt.tens_digit} | bhc_pkg::TILE_BASE;
                res.tile_ones     = {2'd0, nxt.ones_digit} | bhc_pkg::TILE_BASE;
            end
        end
        res.hour_tens = nxt.tens_digit;
        res.hour_ones = nxt.ones_digit;
    end

endmodule

[rtl/bhc_core.sv]
`timescale 1ns / 1ps

module bhc_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  bhc_pkg::cfg_t cfg,
    input  logic          s_valid,
    output logic          s_ready,
    input  bhc_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output bhc_pkg::out_t m_data
);

    logic                in_valid_reg;
    logic                in_valid_next;
    bhc_pkg::in_t        in_data_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    bhc_pkg::out_t       out_data_reg;
    bhc_pkg::clk_state_t state_reg;
    bhc_pkg::clk_state_t state_next;
    bhc_pkg::out_t       step_res;
    logic                advance;

    bhc_step u_step (
        .req (in_data_reg),
        .cfg (cfg),
        .cur (state_reg),
        .nxt (state_next),
        .res (step_res)
    );

    assign advance = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= step_res;
        end
    end

endmodule

[rtl/bcd_hour_clock_with_prescaler.sv]
`timescale 1ns / 1ps
// bcd 24-hour clock driven by frame ticks
// input channel s_*: one request per frame tick (enabled flag, frame phase)
// output channel m_*: exactly one result per request, in order: action code,
//   display address, two tile codes and the current bcd hour digits
// apb port: hour_length at 0x0, start_hour at 0x4, cell_address at 0x8;
//   write only while no request is in flight
// throughput: one request per cycle while m_ready stays high; the step
//   logic sits between the input register and the result register, and
//   the clock state updates when a request moves from one to the other
// stall: while m_ready is low the result holds; one more request is taken
//   into the input register, then s_ready drops until the result is taken
// reset (aresetn low, synchronous): both stages empty, clock state zero
//   (not seeded), registers back to 300, 12 and 0x2038
`include "bcd_hour_clock_with_prescaler_assert.svh"

module bcd_hour_clock_with_prescaler (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bhc_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bhc_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bhc_pkg::out_t                 m_data
);

    bhc_pkg::cfg_t cfg;

    bhc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bhc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // draw shows the reported digits as tiles
    `BHC_ASSERT_NOW(a_draw_tiles, aclk, aresetn,
        m_valid && m_data.action == bhc_pkg::ACT_DRAW,
        m_data.tile_tens == ({4'd0, m_data.hour_tens} | bhc_pkg::TILE_BASE)
        && m_data.tile_ones == ({2'd0, m_data.hour_ones} | bhc_pkg::TILE_BASE))

    // blanking leaves the clock cleared
    `BHC_ASSERT_NOW(a_blank_clears, aclk, aresetn,
        m_valid && m_data.action == bhc_pkg::ACT_BLANK,
        m_data.hour_tens == 2'd0 && m_data.hour_ones == 4'd0
        && m_data.tile_tens == 6'd0 && m_data.tile_ones == 6'd0)

    // reported hour stays a legal 24-hour bcd value
    `BHC_ASSERT_NOW(a_hour_legal, aclk, aresetn,
        m_valid,
        m_data.hour_ones <= 4'd9
        && (m_data.hour_tens < 2'd2 || m_data.hour_ones <= 4'd3))

    // a request taken while no result is held goes on to raise m_valid
    `BHC_ASSERT_NEXT(a_result_follows, aclk, aresetn,
        s_valid && s_ready && !m_valid,
        ##1 m_valid)

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 200000;

    logic                          aclk    = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [bhc_pkg::ADDR_BITS-1:0] paddr   = '0;
    logic [31:0]                   pwdata  = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    bhc_pkg::in_t                  s_data  = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    bhc_pkg::out_t                 m_data;

    // clock state as the testbench sees it
    logic [15:0] countdown = '0;
    logic [1:0]  tens_now  = '0;
    logic [3:0]  ones_now  = '0;
    logic        is_seeded = 1'b0;
    logic [15:0] len_cfg   = bhc_pkg::HOUR_LENGTH_RST;
    logic [4:0]  start_cfg = bhc_pkg::START_HOUR_RST;
    logic [13:0] addr_cfg  = bhc_pkg::CELL_ADDRESS_RST;

    bhc_pkg::out_t pending_ticks[$];
    int   errors     = 0;
    int   cycles     = 0;
    int   idle_pct   = 0;
    int   stall_pct  = 0;

    bcd_hour_clock_with_prescaler i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic bhc_pkg::out_t predict_tick(bhc_pkg::in_t tick);
        bhc_pkg::out_t res;
        logic [4:0]    hour;
        logic [3:0]    ones_inc;
        res = '0;
        res.action = bhc_pkg::ACT_NONE;
        if (!tick.enabled) begin
            if (countdown != 0 || tens_now != 0 || ones_now != 0 || is_seeded) begin
                countdown = '0;
                tens_now  = '0;
                ones_now  = '0;
                is_seeded = 1'b0;
                res.action        = bhc_pkg::ACT_BLANK;
                res.write_address = addr_cfg;
            end
        end else begin
            if (!is_seeded) begin
                hour      = (start_cfg > 5'd23) ? 5'd23 : start_cfg;
                tens_now  = 2'(hour / 5'd10);
                ones_now  = 4'(hour % 5'd10);
                is_seeded = 1'b1;
                countdown = len_cfg;
            end else if (countdown == 0) begin
                ones_inc = ones_now + 4'd1;
                if (ones_inc >= 4'd10) begin
                    ones_now = 4'd0;
                    tens_now = tens_now + 2'd1;
                end else begin
                    ones_now = ones_inc;
                end
                if (tens_now == 2'd2 && ones_now == 4'd4) begin
                    tens_now = 2'd0;
                    ones_now = 4'd0;
                end
                countdown = len_cfg;
            end else begin
                countdown = countdown - 16'd1;
            end
            if (tick.frame_phase == 3'd0) begin
                res.action        = bhc_pkg::ACT_DRAW;
                res.write_address = addr_cfg;
                res.tile_tens     = {4'd0, tens_now} | bhc_pkg::TILE_BASE;
                res.tile_ones     = {2'd0, ones_now} | bhc_pkg::TILE_BASE;
            end
        end
        res.hour_tens = tens_now;
        res.hour_ones = ones_now;
        return res;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        bhc_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_ticks.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $time, m_data);
                errors++;
            end else begin
                want = pending_ticks.pop_front();
                check_field("action", want.action, m_data.action);
                check_field("write_address", want.write_address, m_data.write_address);
                check_field("tile_tens", want.tile_tens, m_data.tile_tens);
                check_field("tile_ones", want.tile_ones, m_data.tile_ones);
                check_field("hour_tens", want.hour_tens, m_data.hour_tens);
                check_field("hour_ones", want.hour_ones, m_data.hour_ones);
            end
        end
    end

    task automatic send_tick(logic en, logic [2:0] phase);
        bhc_pkg::in_t tick;
        tick.enabled     = en;
        tick.frame_phase = phase;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= tick;
        do @(posedge aclk); while (!s_ready);
        pending_ticks.push_back(predict_tick(tick));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_ticks.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bhc_pkg::REG_HOUR_LENGTH:  len_cfg   = val[15:0];
            bhc_pkg::REG_START_HOUR:   start_cfg = val[4:0];
            bhc_pkg::REG_CELL_ADDRESS: addr_cfg  = val[13:0];
            default: ;
        endcase
    endtask

    task automatic set_clock(logic [15:0] len, logic [4:0] start, logic [13:0] addr,
                             logic [31:0] junk);
        wait_drained();
        apb_write(bhc_pkg::REG_HOUR_LENGTH, {junk[15:0], len});
        apb_write(bhc_pkg::REG_START_HOUR, {junk[26:0], start});
        apb_write(bhc_pkg::REG_CELL_ADDRESS, {junk[17:0], addr});
    endtask

    // reset values, idle clear with no state, seed, draw, blank
    task automatic test_power_on();
        send_tick(1'b0, 3'd0);
        send_tick(1'b1, 3'd3);
        send_tick(1'b1, 3'd0);
        send_tick(1'b0, 3'd5);
        send_tick(1'b0, 3'd0);
    endtask

    // zero hour length advances every tick, 23 wraps to 00 and keeps going
    task automatic test_midnight_wrap();
        set_clock(16'd0, 5'd23, 14'h3fff, 32'd0);
        send_tick(1'b1, 3'd0);
        send_tick(1'b1, 3'd0);
        send_tick(1'b1, 3'd0);
        send_tick(1'b1, 3'd4);
        send_tick(1'b0, 3'd7);
    endtask

    // start hour above 23, longest and short hour lengths, upper bits ignored
    task automatic test_saturation_and_lengths();
        set_clock(16'hffff, 5'd31, 14'd0, 32'hffff_ffff);
        send_tick(1'b1, 3'd0);
        send_tick(1'b1, 3'd0);
        send_tick(1'b1, 3'd2);
        send_tick(1'b0, 3'd1);
        set_clock(16'd1, 5'd0, 14'h2000, $urandom);
        send_tick(1'b1, 3'd0);
        send_tick(1'b1, 3'd6);
        send_tick(1'b1, 3'd0);
        send_tick(1'b1, 3'd1);
        send_tick(1'b1, 3'd0);
    endtask

    task automatic test_random_phase(int idle, int stall, int count, logic [15:0] len,
                                     logic [4:0] start, logic [13:0] addr, bit pause);
        set_clock(len, start, addr, 32'd0);
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++) begin
            if (pause && i == count / 2) wait_drained();
            send_tick($urandom_range(99) >= 5, 3'($urandom_range(7)));
        end
        wait_drained();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_power_on();
        test_midnight_wrap();
        test_saturation_and_lengths();
        test_random_phase(0, 0, 190, 16'd0, 5'd23, 14'($urandom), 1'b0);
        test_random_phase(69, 0, 190, 16'd8, 5'($urandom_range(31)), 14'($urandom), 1'b0);
        test_random_phase(0, 69, 190, 16'($urandom_range(5)), 5'd20, 14'($urandom), 1'b0);
        test_random_phase(22, 22, 190, 16'd2, 5'($urandom_range(31)), 14'h3fff, 1'b1);
        wait_drained();
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/bhc_pkg.sv
rtl/bhc_cfg.sv
rtl/bhc_step.sv
rtl/bhc_core.sv
rtl/bcd_hour_clock_with_prescaler.sv
bench/tb.sv
